>>> src/sampled_lru_eviction_set_macros.svh
// Assertion macros for the checker file of the eviction set.
// No dependencies.
`ifndef SAMPLED_LRU_EVICTION_SET_MACROS_SVH
`define SAMPLED_LRU_EVICTION_SET_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define SLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check an implication on every clock edge, reset included.
`define SLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> src/slru_pkg.sv
// Package for the sampled LRU eviction set: sizes, codes and payload types.
// No dependencies.
`timescale 1ns / 1ps
package slru_pkg;
  localparam int SetDepth = 1024;
  localparam int PageIds  = 4096;
  localparam int Samples  = 5;
  localparam int NumRand  = 5;
  localparam int SlotW    = $clog2(SetDepth);
  localparam int CountW   = $clog2(SetDepth + 1);
  localparam int PageW    = 12;
  localparam int QDepth   = 2;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0, KIND_ADD_BYTES = 3'd1, KIND_TOUCH = 3'd2,
    KIND_REMOVE = 3'd3, KIND_QUERY = 3'd4, KIND_EVICT = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDERFLOW = 2'd1, ST_FULL = 2'd2, ST_ABSENT = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] page_id;
    logic [31:0] byte_count;
    logic [63:0] access_time;
    logic [63:0] now_offset;
    logic [15:0] rand_a;
    logic [15:0] rand_b;
    logic [15:0] rand_c;
    logic [15:0] rand_d;
    logic [15:0] rand_e;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_member;
    logic        found;
    logic [11:0] victim_page;
    logic [63:0] total_bytes;
    logic [10:0] entry_count;
  } rsp_t;

  // Item as classified by the front part.
  typedef struct packed {
    logic [2:0]  kind;
    logic        id_ok;
    logic [11:0] page_id;
    logic [31:0] byte_count;
    logic [63:0] access_time;
    logic [63:0] now_offset;
    logic [Samples-1:0][15:0] rnd;
  } cmd_t;
endpackage

>>> src/sampled_lru_eviction_set.sv
// Top level of the sampled LRU eviction set.
// Depends on slru_pkg, slru_front and slru_engine.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive req_i and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy rises
//   only while the two-entry command queue is full.
//   Result channel: one result per command, on rsp_o for exactly one cycle
//   while done_o is high. The receiver cannot stall; take it then.
//   State order: each command passes S_LOOK and then S_DONE, except that
//   a held remove passes S_DEC, S_SUB and S_MOVE between them, and evict on
//   a non-empty set passes S_SAMP, S_SPG and S_AGE per sample, then S_LAST,
//   S_DEC, S_SUB and S_MOVE, set by the sequential reads of the slot and
//   page tables through their single registered read port.
//   Commands run strictly in order, one at a time in the engine, while the
//   front queue keeps accepting until it is full.
//   Reset: clear the queue, the count and the byte total; then the engine
//   clears the page slot table, one entry per cycle for all 4096 page ids, before
//   it takes the first command. The other tables are undefined but never
//   read until written.
module sampled_lru_eviction_set (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  slru_pkg::req_t  req_i,
  output logic            busy,
  output logic            done_o,
  output slru_pkg::rsp_t  rsp_o
);
  import slru_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  slru_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  slru_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_pop_o(cmd_pop), .done_o, .rsp_o
  );
endmodule

>>> src/slru_front.sv
// Front part: take commands, classify them and queue them for the engine.
// Depends on slru_pkg.
`timescale 1ns / 1ps
module slru_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  slru_pkg::req_t    req_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output slru_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);
  import slru_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_new;
  logic [15:0]     words [NumRand];

  assign busy_o = (cnt_q == PtrW'(0) + (PtrW+1)'(QDepth));
  assign push   = start_i && !busy_o;

  always_comb begin
    words[0] = req_i.rand_a;
    words[1] = req_i.rand_b;
    words[2] = req_i.rand_c;
    words[3] = req_i.rand_d;
    words[4] = req_i.rand_e;
    cmd_new.kind        = req_i.kind;
    cmd_new.id_ok       = ({20'd0, req_i.page_id} < 32'(PageIds));
    cmd_new.page_id     = req_i.page_id;
    cmd_new.byte_count  = req_i.byte_count;
    cmd_new.access_time = req_i.access_time;
    cmd_new.now_offset  = req_i.now_offset;
    for (int i = 0; i < Samples; i++) begin
      cmd_new.rnd[i] = words[i % NumRand];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = cmd_pop_i ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];
endmodule

>>> src/slru_engine.sv
// Back part: run one command at a time against the page and slot tables.
// Depends on slru_pkg.
`timescale 1ns / 1ps
module slru_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  slru_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            done_o,
  output slru_pkg::rsp_t  rsp_o
);
  import slru_pkg::*;

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LOOK   = 11'b00000000100,
    S_DEC    = 11'b00000001000,
    S_SAMP   = 11'b00000010000,
    S_SPG    = 11'b00000100000,
    S_AGE    = 11'b00001000000,
    S_LAST   = 11'b00010000000,
    S_MOVE   = 11'b00100000000,
    S_SUB    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  localparam int SampW = $clog2(Samples + 1);

  // Tables; page_slot keeps a held flag above the slot index.
  logic [PageW-1:0] slot_page  [SetDepth];
  logic [63:0]      page_time  [PageIds];
  logic [31:0]      page_bytes [PageIds];
  logic [SlotW:0]   page_slot  [PageIds];

  state_e            st_q;
  cmd_t              c_q;
  logic [CountW-1:0] cnt_q;
  logic [63:0]       tot_q;
  rsp_t              rsp_q;
  logic              done_q;
  logic [SampW-1:0]  si_q;
  logic [SlotW-1:0]  slot_q;
  logic [PageW-1:0]  best_q, cand_q, moved;
  logic [63:0]       best_age_q;
  logic [SlotW-1:0]  hole_q;
  logic [31:0]       sub_q;
  logic [PageW-1:0]  clr_q;

  // Registered memory read ports.
  logic [SlotW:0]   ps_rd;
  logic [63:0]      pt_rd;
  logic [31:0]      pb_rd;
  logic [PageW-1:0] sp_rd;
  logic [PageW-1:0] pg_addr;
  logic [SlotW-1:0] sp_addr;
  logic             held;

  assign held = c_q.id_ok && ps_rd[SlotW];

  always_comb begin
    pg_addr = c_q.page_id;
    if (st_q == S_IDLE) pg_addr = cmd_i.page_id;
    if (st_q == S_SPG || st_q == S_AGE) pg_addr = sp_rd;
    if (st_q == S_LAST) pg_addr = best_q;
    sp_addr = slot_q;
  end

  always_ff @(posedge clk_i) begin
    ps_rd <= page_slot[pg_addr];
    pt_rd <= page_time[pg_addr];
    pb_rd <= page_bytes[pg_addr];
    sp_rd <= slot_page[sp_addr];
  end

  logic [16+CountW-1:0] prod;
  logic [15:0]          rsel;
  logic [63:0]          age;
  logic [16+CountW-1:0] prod_next;
  logic [15:0]          rnext;
  logic [SampW-1:0]     snext;
  assign rsel = c_q.rnd[0];
  assign prod = {{CountW{1'b0}}, rsel} * {16'd0, cnt_q};
  assign age  = c_q.now_offset - pt_rd;

  // Slot of the next sample while waiting on its read.
  assign snext = (si_q < SampW'(Samples - 1)) ? si_q + 1'b1 : si_q;
  assign rnext = c_q.rnd[snext];
  assign prod_next = {{CountW{1'b0}}, rnext} * {16'd0, cnt_q};

  logic [SlotW-1:0] last_slot;
  assign last_slot = SlotW'(cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_INIT: page_slot[clr_q] <= '0;
      S_LOOK: begin
        if (c_q.kind == KIND_ADD && !held && c_q.id_ok
            && cnt_q < CountW'(SetDepth)) begin
          slot_page[cnt_q[SlotW-1:0]] <= c_q.page_id;
          page_slot[c_q.page_id]      <= {1'b1, cnt_q[SlotW-1:0]};
          page_time[c_q.page_id]      <= c_q.access_time;
          page_bytes[c_q.page_id]     <= c_q.byte_count;
        end
        if (c_q.kind == KIND_TOUCH && held)
          page_time[c_q.page_id] <= c_q.access_time;
      end
      S_SUB: page_slot[best_q] <= '0;
      S_MOVE: begin
        if (hole_q != last_slot) begin
          slot_page[hole_q] <= moved;
          page_slot[moved]  <= {1'b1, hole_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; cnt_q <= '0; tot_q <= '0; done_q <= 1'b0;
      si_q <= '0; clr_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        S_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == PageW'(PageIds - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (cmd_valid_i) begin
          c_q   <= cmd_i;
          rsp_q <= '0;
          st_q  <= S_LOOK;
        end
        S_LOOK: begin
          // page tables now read for page_id
          st_q <= S_DONE;
          case (c_q.kind)
            KIND_ADD: begin
              if (!c_q.id_ok || held) rsp_q.status <= ST_ABSENT;
              else if (cnt_q >= CountW'(SetDepth)) rsp_q.status <= ST_FULL;
              else begin
                cnt_q <= cnt_q + 1'b1;
                tot_q <= tot_q + {32'd0, c_q.byte_count};
              end
            end
            KIND_ADD_BYTES: tot_q <= tot_q + {32'd0, c_q.byte_count};
            KIND_TOUCH: if (!held) rsp_q.status <= ST_ABSENT;
            KIND_REMOVE: begin
              if (!held) rsp_q.status <= ST_ABSENT;
              else begin
                best_q <= c_q.page_id;
                sub_q  <= c_q.byte_count;
                st_q   <= S_DEC;
              end
            end
            KIND_QUERY: rsp_q.is_member <= held;
            KIND_EVICT: begin
              if (cnt_q == '0) rsp_q.status <= ST_ABSENT;
              else begin
                si_q   <= '0;
                slot_q <= prod[16 +: SlotW];
                st_q   <= S_SAMP;
              end
            end
            default: ;
          endcase
        end
        S_SAMP: st_q <= S_SPG;       // slot_page read in flight
        S_SPG: begin
          cand_q <= sp_rd;
          st_q   <= S_AGE;
        end
        S_AGE: begin
          if (si_q == '0 || age > best_age_q) begin
            best_q     <= cand_q;
            best_age_q <= age;
          end
          if (si_q == SampW'(Samples - 1)) begin
            st_q <= S_LAST;
          end else begin
            si_q   <= si_q + 1'b1;
            slot_q <= prod_next[16 +: SlotW];
            st_q   <= S_SAMP;
          end
        end
        S_LAST: begin
          // index slot set up for best; reads land next cycle
          st_q <= S_DEC;
        end
        S_DEC: begin
          // ps_rd/pb_rd hold the victim's slot and size
          hole_q <= ps_rd[SlotW-1:0];
          slot_q <= last_slot;
          if (c_q.kind == KIND_EVICT) begin
            sub_q <= pb_rd;
            rsp_q.found <= 1'b1;
            rsp_q.victim_page <= best_q;
          end
          st_q <= S_SUB;
        end
        S_SUB: begin
          // last slot's page read is in flight
          st_q <= S_MOVE;
          if ({32'd0, sub_q} > tot_q) begin
            tot_q <= '0;
            rsp_q.status <= ST_UNDERFLOW;
          end else begin
            tot_q <= tot_q - {32'd0, sub_q};
          end
        end
        S_MOVE: begin
          cnt_q <= cnt_q - 1'b1;
          st_q <= S_DONE;
        end
        S_DONE: begin
          done_q <= 1'b1;
          rsp_q.total_bytes <= tot_q;
          rsp_q.entry_count <= 11'(cnt_q);
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // moved page comes from the registered slot_page read in S_MOVE
  assign moved = sp_rd;

  assign cmd_pop_o = (st_q == S_IDLE) && cmd_valid_i;
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;
endmodule

>>> src/slru_checker.sv
// Port checker for the sampled LRU eviction set, bound to the top level.
// Depends on slru_pkg and the macro header.
`timescale 1ns / 1ps
`include "sampled_lru_eviction_set_macros.svh"
module slru_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy,
  input logic           done_o,
  input slru_pkg::rsp_t rsp_o
);
  import slru_pkg::*;
  `SLE_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "done held two cycles")
  `SLE_ASSERT(a_cnt_range, clk_i, rst_ni, done_o |-> rsp_o.entry_count <= 11'(SetDepth), "count too large")
  `SLE_ASSERT(a_found_evict, clk_i, rst_ni, (done_o && rsp_o.found) |-> (rsp_o.status != ST_FULL && !rsp_o.is_member), "found with bad fields")
  `SLE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!done_o && !busy), "activity in reset")
endmodule

bind sampled_lru_eviction_set slru_checker u_chk (
  .clk_i, .rst_ni, .busy, .done_o, .rsp_o
);

>>> bench/sampled_lru_eviction_set_tb.sv
// Testbench for the sampled LRU eviction set: directed and random command
// transactions, checked against an in-bench model of the set. Depends on slru_pkg.
`timescale 1ns / 1ps
module sampled_lru_eviction_set_tb;
  import slru_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  sampled_lru_eviction_set u_top (
    .clk_i (clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy  (busy), .done_o(done_o), .rsp_o(rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model of the set: dense slot list plus per-page tables.
  logic [11:0] slot_list [SetDepth];
  logic [63:0] page_stamp [PageIds];
  logic [31:0] page_size [PageIds];
  logic [10:0] page_pos [PageIds];
  bit          page_held [PageIds];
  int unsigned held_n;
  logic [63:0] bytes_sum;

  req_t pending_cmds [$];
  rsp_t expected_rsps [$];
  int   mismatches;
  int   accepted;
  int   checked;
  int   evictions;
  bit   quiet_tail;   // no idling in the last part of the run
  int   drv_gap;

  // Drop a held page; the last slot fills the hole.
  function automatic void unlink_page(input logic [11:0] id);
    int unsigned hole;
    logic [11:0] moved;
    hole = page_pos[id];
    if (hole != held_n - 1) begin
      moved = slot_list[held_n - 1];
      slot_list[hole] = moved;
      page_pos[moved] = hole[10:0];
    end
    page_held[id] = 1'b0;
    held_n--;
  endfunction

  // Saturating subtract from the byte total; returns the status.
  function automatic logic [1:0] take_bytes(input logic [63:0] amount);
    if (amount > bytes_sum) begin
      bytes_sum = '0;
      return ST_UNDERFLOW;
    end
    bytes_sum -= amount;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_set_op(input req_t c);
    rsp_t r;
    logic [15:0] words [NumRand];
    logic [11:0] best;
    logic [11:0] pg;
    logic [63:0] best_age;
    logic [63:0] age;
    logic [31:0] slot;
    r = '0;
    case (c.kind)
      KIND_ADD: begin
        if (page_held[c.page_id]) r.status = ST_ABSENT;
        else if (held_n >= SetDepth) r.status = ST_FULL;
        else begin
          slot_list[held_n] = c.page_id;
          page_pos[c.page_id] = held_n[10:0];
          page_held[c.page_id] = 1'b1;
          page_stamp[c.page_id] = c.access_time;
          page_size[c.page_id] = c.byte_count;
          held_n++;
          bytes_sum += {32'd0, c.byte_count};
        end
      end
      KIND_ADD_BYTES: bytes_sum += {32'd0, c.byte_count};
      KIND_TOUCH: begin
        if (page_held[c.page_id]) page_stamp[c.page_id] = c.access_time;
        else r.status = ST_ABSENT;
      end
      KIND_REMOVE: begin
        if (page_held[c.page_id]) begin
          unlink_page(c.page_id);
          r.status = take_bytes({32'd0, c.byte_count});
        end else r.status = ST_ABSENT;
      end
      KIND_QUERY: r.is_member = page_held[c.page_id];
      KIND_EVICT: begin
        if (held_n == 0) r.status = ST_ABSENT;
        else begin
          words[0] = c.rand_a; words[1] = c.rand_b; words[2] = c.rand_c;
          words[3] = c.rand_d; words[4] = c.rand_e;
          best = '0;
          best_age = '0;
          for (int i = 0; i < Samples; i++) begin
            slot = (32'(words[i % NumRand]) * held_n) >> 16;
            pg = slot_list[slot];
            age = c.now_offset - page_stamp[pg];
            if (i == 0 || age > best_age) begin
              best = pg;
              best_age = age;
            end
          end
          r.found = 1'b1;
          r.victim_page = best;
          unlink_page(best);
          r.status = take_bytes({32'd0, page_size[best]});
        end
      end
      default: ;
    endcase
    r.total_bytes = bytes_sum;
    r.entry_count = held_n[10:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t make_cmd(input logic [2:0] k, input logic [11:0] id,
                                    input logic [31:0] b);
    req_t c;
    c.kind = k; c.page_id = id; c.byte_count = b;
    c.access_time = rand64(); c.now_offset = rand64();
    c.rand_a = 16'($urandom()); c.rand_b = 16'($urandom());
    c.rand_c = 16'($urandom()); c.rand_d = 16'($urandom());
    c.rand_e = 16'($urandom());
    return c;
  endfunction

  // Driver: advance to the next pending transaction once the current one is
  // taken; insert random idle bursts between transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_set_op(req_i));
        accepted++;
      end
      if (!start || !busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          start <= 1'b0;
        end else if (!quiet_tail && start && !busy && $urandom_range(0, 5) == 0) begin
          drv_gap = $urandom_range(0, 9);
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          req_i <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_o);
      end else begin
        exp_r = expected_rsps.pop_front();
        checked++;
        if (exp_r.found) evictions++;
        if (rsp_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p, got %p", checked, exp_r, rsp_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [11:0] id;
    int k;
    held_n = 0;
    bytes_sum = '0;
    mismatches = 0; accepted = 0; checked = 0; evictions = 0;
    quiet_tail = 1'b0; drv_gap = 0;
    for (int i = 0; i < PageIds; i++) page_held[i] = 1'b0;

    // Directed: evict, touch, remove and query on an empty set, extremes, duplicates,
    // large byte counts on the total, absent pages, unused kinds.
    pending_cmds.push_back(make_cmd(KIND_EVICT, 12'd0, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_TOUCH, 12'd7, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_REMOVE, 12'd7, 32'd5));
    pending_cmds.push_back(make_cmd(KIND_QUERY, 12'hFFF, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_ADD, 12'hFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(KIND_ADD, 12'hFFF, 32'd1));
    pending_cmds.push_back(make_cmd(KIND_ADD, 12'd0, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_QUERY, 12'hFFF, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_TOUCH, 12'd0, 32'd0));
    pending_cmds.push_back(make_cmd(3'd6, 12'd3, 32'd9));
    pending_cmds.push_back(make_cmd(3'd7, 12'hFFF, 32'hFFFF_FFFF));
    for (int i = 0; i < 4; i++)
      pending_cmds.push_back(make_cmd(KIND_ADD_BYTES, 12'h555, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(KIND_REMOVE, 12'd0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(KIND_ADD, 12'hAAA, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(KIND_EVICT, 12'd0, 32'd0));
    pending_cmds.push_back(make_cmd(KIND_REMOVE, 12'hFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(KIND_EVICT, 12'd0, 32'd0));

    // Random: mixes, unused kinds included, on a small pool of ids so hits dominate.
    for (int i = 0; i < 680; i++) begin
      k = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 63));
      if (k < 30) pending_cmds.push_back(make_cmd(KIND_ADD, id, $urandom()));
      else if (k < 35) pending_cmds.push_back(make_cmd(KIND_ADD_BYTES, id, $urandom()));
      else if (k < 50) pending_cmds.push_back(make_cmd(KIND_TOUCH, id, 0));
      else if (k < 62) pending_cmds.push_back(make_cmd(KIND_REMOVE, id, $urandom()));
      else if (k < 72) pending_cmds.push_back(make_cmd(KIND_QUERY, id, 0));
      else if (k < 98) pending_cmds.push_back(make_cmd(KIND_EVICT, id, 0));
      else pending_cmds.push_back(make_cmd(3'($urandom_range(6, 7)), id, $urandom()));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold idling off once only the last stretch of commands remains.
    wait (pending_cmds.size() < 100);
    quiet_tail = 1'b1;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("covered %0d transactions, %0d checked results, %0d evictions",
             accepted, checked, evictions);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
